// ===== sv/cglu_pkg.sv =====
package cglu_pkg;

    // default table depth
    localparam int MAX_STOPS_DEF = 8;

    // field widths
    localparam int IDX_W   = 3;
    localparam int TIME_W  = 16;
    localparam int CHAN_W  = 8;
    localparam int COLOR_W = 4 * CHAN_W;
    localparam int ID_W    = 16;
    localparam int CNT_W   = 4;
    localparam int ENTRY_W = TIME_W + COLOR_W;

    // packed stream widths
    localparam int S_DATA_W = 88;
    localparam int M_DATA_W = 48;

    // item kinds carried on tuser
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // stop count after reset
    localparam logic [CNT_W-1:0] STOP_COUNT_RESET = 4'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIV,
        ST_FINISH
    } cglu_state_t;

    // stop time of an entry that was never written
    function automatic logic [TIME_W-1:0] stop_reset_time(input int unsigned idx);
        logic [TIME_W-1:0] t;
        case (idx)
            0:       t = 16'd0;
            1:       t = 16'd9830;
            2:       t = 16'd22938;
            3:       t = 16'd32768;
            4:       t = 16'd32768;
            default: t = 16'd0;
        endcase
        return t;
    endfunction

    // stop color of an entry that was never written, red in the low byte
    function automatic logic [COLOR_W-1:0] stop_reset_color(input int unsigned idx);
        logic [COLOR_W-1:0] c;
        case (idx)
            0:       c = 32'hFFCC_FFFF;
            1:       c = 32'hFF00_80FF;
            2:       c = 32'h8000_1ACC;
            3:       c = 32'h0000_0033;
            default: c = 32'h0000_0000;
        endcase
        return c;
    endfunction

endpackage

// ===== sv/color_gradient_lerp_unit.sv =====
// Piecewise linear color gradient. The stop table (time and RGBA color per stop) sits in
// one synchronous memory of MAX_STOPS entries; entries never written read as the built-in
// fire gradient. A write item (tuser = 0) stores one stop and returns a zero color. A
// query item (tuser = 1) reads the stops one per cycle, comparing each segment against
// the age, then runs a 16-step restoring divider for the fraction when the segment has a
// nonzero span, and a lerp step. It reads only stop 0 when the active stop count is 0 or
// 1, else at most the active stop count. One item is in work at a time; its result waits
// in the output register while the next item is taken. Stop count is written on the cfg
// channel, which is always ready.
module color_gradient_lerp_unit
    import cglu_pkg::*;
#(
    parameter int MAX_STOPS = MAX_STOPS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,

    // cfg write: stop count
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CNT_W-1:0]    cfg_data,

    // input items
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // stop_index[2:0], stop_time[18:3], stop_red[26:19], stop_green[34:27],
    // stop_blue[42:35], stop_alpha[50:43], age[66:51], particle_id[82:67], zero pad
    input  logic [S_DATA_W-1:0] s_axis_tdata,
    // func[0]
    input  logic                s_axis_tuser,

    // result items
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // result_id[15:0], red[23:16], green[31:24], blue[39:32], alpha[47:40]
    output logic [M_DATA_W-1:0] m_axis_tdata
);

    localparam int AW = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;
    localparam int CW = $clog2(MAX_STOPS + 1);

    // input field unpacking
    logic [IDX_W-1:0]   in_stop_index;
    logic [TIME_W-1:0]  in_stop_time;
    logic [COLOR_W-1:0] in_stop_color;
    logic [TIME_W-1:0]  in_age;
    logic [ID_W-1:0]    in_particle_id;

    assign in_stop_index  = s_axis_tdata[2:0];
    assign in_stop_time   = s_axis_tdata[18:3];
    assign in_stop_color  = s_axis_tdata[50:19];
    assign in_age         = s_axis_tdata[66:51];
    assign in_particle_id = s_axis_tdata[82:67];

    // stop table memory with per-entry written bits
    logic [ENTRY_W-1:0]   mem [MAX_STOPS];
    logic [MAX_STOPS-1:0] written_reg, written_next;
    logic                 mem_we;
    logic [AW-1:0]        mem_wr_addr;
    logic [AW-1:0]        rd_addr;
    logic [ENTRY_W-1:0]   rd_data_reg;
    logic                 rd_written_reg;
    logic [AW-1:0]        rd_addr_reg;

    // control and payload registers
    cglu_state_t          state_reg, state_next;
    logic [CNT_W-1:0]     stop_count_reg, stop_count_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [AW-1:0]        idx_reg, idx_next;
    logic [TIME_W-1:0]    age_reg, age_next;
    logic [ID_W-1:0]      id_reg, id_next;
    logic [TIME_W-1:0]    prev_time_reg, prev_time_next;
    logic [COLOR_W-1:0]   prev_color_reg, prev_color_next;
    logic [COLOR_W-1:0]   c0_reg, c0_next;
    logic [COLOR_W-1:0]   c1_reg, c1_next;
    logic [16:0]          rem_reg, rem_next;
    logic [TIME_W-1:0]    den_reg, den_next;
    logic [15:0]          quo_reg, quo_next;
    logic [3:0]           div_cnt_reg, div_cnt_next;
    logic                 m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0]  m_data_reg, m_data_next;

    // entry as seen by the scan
    logic [TIME_W-1:0]    cur_time;
    logic [COLOR_W-1:0]   cur_color;

    // datapath helpers
    logic [16:0]          trial;
    logic                 out_free;
    logic [COLOR_W-1:0]   lerp_color;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    assign cur_time  = rd_written_reg ? rd_data_reg[ENTRY_W-1:COLOR_W]
                                      : stop_reset_time(int'(rd_addr_reg));
    assign cur_color = rd_written_reg ? rd_data_reg[COLOR_W-1:0]
                                      : stop_reset_color(int'(rd_addr_reg));

    assign out_free = !m_valid_reg || m_axis_tready;

    // read address: next entry while scanning, entry 0 otherwise
    assign rd_addr = (state_reg == ST_SCAN) ? idx_reg + AW'(1) : '0;

    // memory write port and registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wr_addr] <= {in_stop_time, in_stop_color};
        end
        rd_data_reg    <= mem[rd_addr];
        rd_written_reg <= written_reg[rd_addr];
        rd_addr_reg    <= rd_addr;
    end

    // restoring divider step: no shift on the first quotient bit
    assign trial = (div_cnt_reg == 4'd15) ? rem_reg : {rem_reg[15:0], 1'b0};

    // per-channel lerp: c0 + floor((c1 - c0) * frac / 32768)
    always_comb
    begin
        logic signed [8:0]  diff;
        logic signed [25:0] prod;
        logic signed [25:0] step;
        for (int ch = 0; ch < 4; ch++)
        begin
            diff = $signed({1'b0, c1_reg[ch*CHAN_W +: CHAN_W]})
                 - $signed({1'b0, c0_reg[ch*CHAN_W +: CHAN_W]});
            prod = 26'(diff) * $signed({10'd0, quo_reg});
            step = prod >>> 15;
            lerp_color[ch*CHAN_W +: CHAN_W] = c0_reg[ch*CHAN_W +: CHAN_W] + step[7:0];
        end
    end

    // next state and datapath control
    always_comb
    begin
        state_next      = state_reg;
        stop_count_next = stop_count_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        age_next        = age_reg;
        id_next         = id_reg;
        prev_time_next  = prev_time_reg;
        prev_color_next = prev_color_reg;
        c0_next         = c0_reg;
        c1_next         = c1_reg;
        rem_next        = rem_reg;
        den_next        = den_reg;
        quo_next        = quo_reg;
        div_cnt_next    = div_cnt_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        written_next    = written_reg;
        mem_we          = 1'b0;
        mem_wr_addr     = AW'(in_stop_index);

        // stop count register
        if (cfg_valid)
        begin
            stop_count_next = cfg_data;
        end

        // output register drains
        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    id_next  = in_particle_id;
                    age_next = in_age;
                    idx_next = '0;
                    if (32'(stop_count_reg) > MAX_STOPS)
                    begin
                        count_next = CW'(MAX_STOPS);
                    end
                    else
                    begin
                        count_next = CW'(stop_count_reg);
                    end
                    if (s_axis_tuser == FUNC_WRITE)
                    begin
                        // store the stop, answer with zero color
                        if (32'(in_stop_index) < MAX_STOPS)
                        begin
                            mem_we                    = 1'b1;
                            written_next[mem_wr_addr] = 1'b1;
                        end
                        c0_next    = '0;
                        c1_next    = '0;
                        quo_next   = '0;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                if (idx_reg == '0)
                begin
                    if (count_reg <= CW'(1))
                    begin
                        // single stop or none: stop 0
                        c0_next    = cur_color;
                        c1_next    = cur_color;
                        quo_next   = '0;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        prev_time_next  = cur_time;
                        prev_color_next = cur_color;
                        idx_next        = idx_reg + AW'(1);
                    end
                end
                else if (age_reg >= prev_time_reg && age_reg <= cur_time)
                begin
                    // matching segment
                    c0_next  = prev_color_reg;
                    c1_next  = cur_color;
                    quo_next = '0;
                    if (cur_time > prev_time_reg)
                    begin
                        rem_next     = {1'b0, age_reg - prev_time_reg};
                        den_next     = cur_time - prev_time_reg;
                        div_cnt_next = 4'd15;
                        state_next   = ST_DIV;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
                else if (CW'(idx_reg) + CW'(1) == count_reg)
                begin
                    // no segment matched: last active stop
                    c0_next    = cur_color;
                    c1_next    = cur_color;
                    quo_next   = '0;
                    state_next = ST_FINISH;
                end
                else
                begin
                    prev_time_next  = cur_time;
                    prev_color_next = cur_color;
                    idx_next        = idx_reg + AW'(1);
                end
            end

            ST_DIV:
            begin
                // one quotient bit per cycle
                if (trial >= {1'b0, den_reg})
                begin
                    rem_next = trial - {1'b0, den_reg};
                    quo_next = {quo_reg[14:0], 1'b1};
                end
                else
                begin
                    rem_next = trial;
                    quo_next = {quo_reg[14:0], 1'b0};
                end
                div_cnt_next = div_cnt_reg - 4'd1;
                if (div_cnt_reg == 4'd0)
                begin
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                // lerp into the output register once it is free
                if (out_free)
                begin
                    m_data_next  = {lerp_color, id_reg};
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            stop_count_reg <= STOP_COUNT_RESET;
            written_reg    <= '0;
            m_valid_reg    <= 1'b0;
            count_reg      <= '0;
            idx_reg        <= '0;
            div_cnt_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            stop_count_reg <= stop_count_next;
            written_reg    <= written_next;
            m_valid_reg    <= m_valid_next;
            count_reg      <= count_next;
            idx_reg        <= idx_next;
            div_cnt_reg    <= div_cnt_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        age_reg        <= age_next;
        id_reg         <= id_next;
        prev_time_reg  <= prev_time_next;
        prev_color_reg <= prev_color_next;
        c0_reg         <= c0_next;
        c1_reg         <= c1_next;
        rem_reg        <= rem_next;
        den_reg        <= den_next;
        quo_reg        <= quo_next;
        m_data_reg     <= m_data_next;
    end

endmodule
